FILE: hdl/sem_pkg.sv
// shared types and constants of the sobel edge magnitude core
`timescale 1ns / 1ps
package sem_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 8;
   localparam int COUNT_LIMIT    = 1024;
   localparam int CNT_W          = 10;
   localparam int CFG_W          = 11;
   localparam int PIX_W          = 8;
   localparam int MAG_W          = 8;
   localparam int MAG_MAX        = 255;
   localparam int QDEPTH         = 4;
   localparam int QPTR_W         = $clog2(QDEPTH);
   localparam int QCNT_W         = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W      = 1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // pixel position and class, from the counters to the datapath
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic             border;
      logic             interior;
   } issue_type;

   typedef struct packed {
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic [MAG_W-1:0] mag;
      logic             border;
      logic             interior;
   } res_type;

   typedef struct packed {
      logic    valid;
      res_type res;
   } push_type;

endpackage

FILE: hdl/sem_req_if.sv
// pixel input channel
`timescale 1ns / 1ps
interface sem_req_if;
   import sem_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

FILE: hdl/sem_rsp_if.sv
// edge magnitude result channel
`timescale 1ns / 1ps
interface sem_rsp_if;
   import sem_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] out_row;
   logic [CNT_W-1:0] out_col;
   logic [MAG_W-1:0] magnitude;
   logic             last_of_run;

   modport source (output valid, output out_row, output out_col, output magnitude,
                   output last_of_run, input ready);
   modport sink (input valid, input out_row, input out_col, input magnitude,
                 input last_of_run, output ready);
endinterface

FILE: hdl/sem_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/sem_front.sv
// front end: frame registers, position counters, item classification and admission
`timescale 1ns / 1ps
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CFG_W-1:0]     csr_wdata,
   sem_req_if.sink                       req_chan,
   input  logic                          clr_busy,
   input  logic                          s1_busy,
   input  logic [sem_pkg::QCNT_W-1:0]    q_count,
   output sem_pkg::issue_type            issue,
   output logic [PIXEL_BITS-1:0]         issue_pixel
);
   import sem_pkg::*;

   localparam int LIM = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;

   logic [CFG_W-1:0] w_eff, h_eff;
   logic [CFG_W-1:0] row_adv, col_nxt, row_nxt;
   logic [CNT_W-1:0] r, c;
   logic             line_wrap, accept;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en && csr_index == CSR_FRAME_WIDTH) begin
         frame_width_in = csr_wdata;
      end
      if (csr_wr_en && csr_index == CSR_FRAME_HEIGHT) begin
         frame_height_in = csr_wdata;
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (frame_width_ff > CFG_W'(LIM)) begin
         w_eff = CFG_W'(LIM);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (frame_height_ff > CFG_W'(COUNT_LIMIT)) begin
         h_eff = CFG_W'(COUNT_LIMIT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // a narrowed width can leave the column past the line end
   always_comb begin
      line_wrap = {1'b0, col_ff} >= w_eff;
      row_adv   = {1'b0, row_ff} + CFG_W'(line_wrap);
      r         = (row_adv >= h_eff) ? '0 : row_adv[CNT_W-1:0];
      c         = line_wrap ? '0 : col_ff;
   end

   always_comb begin
      col_nxt = {1'b0, c} + CFG_W'(1);
      row_nxt = {1'b0, r};
      if (col_nxt >= w_eff) begin
         col_nxt = '0;
         row_nxt = {1'b0, r} + CFG_W'(1);
         if (row_nxt >= h_eff) begin
            row_nxt = '0;
         end
      end
   end

   assign req_chan.ready = !clr_busy
                           && (q_count + QCNT_W'(s1_busy)) < QCNT_W'(QDEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         row_in = row_nxt[CNT_W-1:0];
         col_in = col_nxt[CNT_W-1:0];
      end
   end

   always_comb begin
      issue.valid    = accept;
      issue.row      = r;
      issue.col      = c;
      issue.border   = (r == '0) || ({1'b0, r} == h_eff - CFG_W'(1))
                       || (c == '0) || ({1'b0, c} == w_eff - CFG_W'(1));
      issue.interior = (r >= CNT_W'(2)) && (c >= CNT_W'(2));
      issue_pixel    = PIXEL_BITS'(req_chan.pixel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

`ifndef SYNTH
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !accept)
      else $error("item taken during line buffer clear");
`endif
endmodule

FILE: hdl/sem_exec.sv
// datapath: line buffers with clear sweep, 3x3 window and gradient magnitude
`timescale 1ns / 1ps
module sem_exec #(
   parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sem_pkg::issue_type    issue,
   input  logic [PIXEL_BITS-1:0] issue_pixel,
   output logic                  clr_busy,
   output logic                  s1_busy,
   output sem_pkg::push_type     push
);
   import sem_pkg::*;

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int SW   = PIXEL_BITS + 3;
   localparam int CMPW = (SW > 9) ? SW : 9;

   logic                  clr_busy_ff, clr_busy_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  s1_valid_ff;
   logic [CNT_W-1:0]      s1_row_ff, s1_col_ff;
   logic                  s1_border_ff, s1_interior_ff, s1_fwd_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [PIXEL_BITS-1:0] wr_m_ff, wr_b_ff;
   logic [PIXEL_BITS-1:0] win_ff [6];

   logic [PIXEL_BITS-1:0] two_rd, above_rd;
   logic [PIXEL_BITS-1:0] t_eff, m_eff, b_px;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [PIXEL_BITS-1:0] wr_two_data, wr_above_data;

   logic [SW-1:0]         pos_x, neg_x, pos_y, neg_y, abs_x, abs_y, mag_sum;
   logic signed [SW-1:0]  gx, gy;
   logic [MAG_W-1:0]      mag;

   assign rd_addr = AW'(issue.col);

   sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_two_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_two_data),
      .rd_en   (issue.valid),
      .rd_addr (rd_addr),
      .rd_data (two_rd)
   );

   sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_above_data),
      .rd_en   (issue.valid),
      .rd_addr (rd_addr),
      .rd_data (above_rd)
   );

   // the read misses a write to the same column in the same cycle
   assign t_eff = s1_fwd_ff ? wr_m_ff : two_rd;
   assign m_eff = s1_fwd_ff ? wr_b_ff : above_rd;
   assign b_px  = s1_pixel_ff;

   always_comb begin
      wr_en         = clr_busy_ff || s1_valid_ff;
      wr_addr       = clr_busy_ff ? clr_addr_ff : AW'(s1_col_ff);
      wr_two_data   = clr_busy_ff ? '0 : m_eff;
      wr_above_data = clr_busy_ff ? '0 : b_px;
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      pos_x = SW'(t_eff) + SW'({m_eff, 1'b0}) + SW'(b_px);
      neg_x = SW'(win_ff[0]) + SW'({win_ff[1], 1'b0}) + SW'(win_ff[2]);
      pos_y = SW'(win_ff[0]) + SW'({win_ff[3], 1'b0}) + SW'(t_eff);
      neg_y = SW'(win_ff[2]) + SW'({win_ff[5], 1'b0}) + SW'(b_px);
      gx    = $signed(pos_x) - $signed(neg_x);
      gy    = $signed(pos_y) - $signed(neg_y);
      abs_x = gx[SW-1] ? SW'(-gx) : SW'(gx);
      abs_y = gy[SW-1] ? SW'(-gy) : SW'(gy);
      mag_sum = abs_x + abs_y;
      if (CMPW'(mag_sum) >= CMPW'(MAG_MAX)) begin
         mag = MAG_W'(MAG_MAX);
      end else begin
         mag = MAG_W'(mag_sum);
      end
   end

   always_comb begin
      push.valid        = s1_valid_ff && (s1_border_ff || s1_interior_ff);
      push.res.row      = s1_row_ff;
      push.res.col      = s1_col_ff;
      push.res.mag      = mag;
      push.res.border   = s1_border_ff;
      push.res.interior = s1_interior_ff;
   end

   assign clr_busy = clr_busy_ff;
   assign s1_busy  = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= issue.valid;
         if (s1_valid_ff) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= t_eff;
            win_ff[4] <= m_eff;
            win_ff[5] <= b_px;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff      <= issue.row;
      s1_col_ff      <= issue.col;
      s1_border_ff   <= issue.border;
      s1_interior_ff <= issue.interior;
      s1_pixel_ff    <= issue_pixel;
      s1_fwd_ff      <= s1_valid_ff && (issue.col == s1_col_ff);
      if (s1_valid_ff) begin
         wr_m_ff <= m_eff;
         wr_b_ff <= b_px;
      end
   end

`ifndef SYNTH
   a_clear_blocks_datapath : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff)
      else $error("pixel in flight during line buffer clear");
`endif
endmodule

FILE: hdl/sem_back.sv
// back end: result queue and emission of one or two results per item
`timescale 1ns / 1ps
module sem_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sem_pkg::push_type          push,
   output logic [sem_pkg::QCNT_W-1:0] q_count,
   sem_rsp_if.source                  rsp_chan
);
   import sem_pkg::*;

   res_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               phase_ff, phase_in;

   res_type            head;
   logic               emit_interior, fire, pop;

   assign head          = q_ff[rd_ptr_ff];
   assign emit_interior = head.interior && !phase_ff;

   always_comb begin
      rsp_chan.valid = count_ff != '0;
      if (emit_interior) begin
         rsp_chan.out_row     = head.row - CNT_W'(1);
         rsp_chan.out_col     = head.col - CNT_W'(1);
         rsp_chan.magnitude   = head.mag;
         rsp_chan.last_of_run = !head.border;
      end else begin
         rsp_chan.out_row     = head.row;
         rsp_chan.out_col     = head.col;
         rsp_chan.magnitude   = '0;
         rsp_chan.last_of_run = 1'b1;
      end
   end

   assign fire = rsp_chan.valid && rsp_chan.ready;
   assign pop  = fire && !(emit_interior && head.border);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
         phase_in  = 1'b0;
      end else if (fire) begin
         // interior result sent, border zero of the same item still due
         phase_in = 1'b1;
      end
      count_in = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   assign q_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_ff[wr_ptr_ff] <= push.res;
      end
   end

`ifndef SYNTH
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("result queue over capacity");
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(QDEPTH)) |-> !push.valid)
      else $error("push into full result queue");
   a_phase_only_split : assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (count_ff != '0 && head.interior && head.border))
      else $error("split emission on an item without two results");
`endif
endmodule

FILE: hdl/sobel_edge_magnitude_core.sv
// 3x3 sobel edge magnitude over a raster pixel stream
// Usage: one grayscale pixel per item on req_chan in raster order, results on
// rsp_chan as (out_row, out_col, magnitude, last_of_run). Border pixels give a
// zero result at their own position when they arrive; an interior pixel's
// result comes out when the pixel one row down and one column right arrives,
// ahead of that pixel's own border zero if it has one. last_of_run marks the
// final result caused by an item. csr_wr_en with csr_index 0 or 1 writes
// frame_width or frame_height; write only while no item is in flight.
// Throughput: one pixel per cycle while results are drained; an item that
// causes two results holds the output until both are taken. A result passes
// through the stage holding the line buffer ram read and the magnitude, then
// the result queue, before it can be taken. A four-entry result queue lets the
// input keep moving while rsp_chan is stalled; once its entries and the item
// in the magnitude stage reach four, req_chan.ready drops until an entry leaves.
// Reset: counters return to row 0 column 0, the frame registers to 640x480,
// and both line buffers are cleared, one column per cycle, while req_chan.ready
// stays low.
`timescale 1ns / 1ps
module sobel_edge_magnitude_core #(
   parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CFG_W-1:0]     csr_wdata,
   sem_req_if.sink                       req_chan,
   sem_rsp_if.source                     rsp_chan
);
   import sem_pkg::*;

   issue_type             issue;
   logic [PIXEL_BITS-1:0] issue_pixel;
   logic                  clr_busy, s1_busy;
   logic [QCNT_W-1:0]     q_count;
   push_type              push;

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_chan    (req_chan),
      .clr_busy    (clr_busy),
      .s1_busy     (s1_busy),
      .q_count     (q_count),
      .issue       (issue),
      .issue_pixel (issue_pixel)
   );

   sem_exec #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_exec (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .issue_pixel (issue_pixel),
      .clr_busy    (clr_busy),
      .s1_busy     (s1_busy),
      .push        (push)
   );

   sem_back u_back (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .q_count  (q_count),
      .rsp_chan (rsp_chan)
   );
endmodule

FILE: tb/sem_result_checker.sv
// scoreboard for the sobel core: predicts results from accepted pixels and compares them
`timescale 1ns / 1ps
module sem_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CFG_W-1:0]     csr_wdata,
   sem_req_if                            req_mon,
   sem_rsp_if                            rsp_mon,
   output int                            outstanding,
   output int                            fail_count
);
   import sem_pkg::*;

   localparam int WIDTH_LIMIT = (DEF_MAX_WIDTH < COUNT_LIMIT) ? DEF_MAX_WIDTH : COUNT_LIMIT;

   typedef struct packed {
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic [MAG_W-1:0] mag;
      logic             last;
   } edge_result_type;

   edge_result_type  edge_results_q[$];
   logic [PIX_W-1:0] row_above     [COUNT_LIMIT];
   logic [PIX_W-1:0] row_two_above [COUNT_LIMIT];
   logic [PIX_W-1:0] win           [6];
   int               next_row;
   int               next_col;
   logic [CFG_W-1:0] frame_w;
   logic [CFG_W-1:0] frame_h;

   function automatic int eff_size(input logic [CFG_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   // win[0..2] is column c-2, win[3..5] is column c-1, (t, m, b) is column c
   function automatic logic [MAG_W-1:0] edge_mag(input int t, input int m, input int b);
      int p00, p10, p20, p01, p21, gx, gy, sum;
      p00 = int'(win[0]);
      p10 = int'(win[1]);
      p20 = int'(win[2]);
      p01 = int'(win[3]);
      p21 = int'(win[5]);
      gx  = (t + 2 * m + b) - (p00 + 2 * p10 + p20);
      gy  = (p00 + 2 * p01 + t) - (p20 + 2 * p21 + b);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      sum = gx + gy;
      if (sum >= MAG_MAX) return MAG_W'(MAG_MAX);
      return MAG_W'(sum);
   endfunction

   task automatic queue_result(input edge_result_type res);
      edge_results_q = {edge_results_q, res};
   endtask

   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      int w, h, r, c, t, m, b;
      bit on_border, is_interior;
      w = eff_size(frame_w, WIDTH_LIMIT);
      h = eff_size(frame_h, COUNT_LIMIT);
      // width may have shrunk under the column counter
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      r = next_row;
      c = next_col;
      b = int'(pix);
      t = int'(row_two_above[c]);
      m = int'(row_above[c]);
      on_border   = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
      is_interior = (r >= 2) && (c >= 2);
      if (is_interior)
         queue_result('{CNT_W'(r - 1), CNT_W'(c - 1), edge_mag(t, m, b), !on_border});
      if (on_border)
         queue_result('{CNT_W'(r), CNT_W'(c), '0, 1'b1});
      row_two_above[c] = PIX_W'(m);
      row_above[c]     = pix;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(t);
      win[4] = PIX_W'(m);
      win[5] = pix;
      next_col = c + 1;
      next_row = r;
      if (next_col >= w) begin
         next_col = 0;
         next_row = r + 1;
         if (next_row >= h) next_row = 0;
      end
   endtask

   task automatic check_result();
      edge_result_type exp_res;
      if (edge_results_q.size() == 0) begin
         $error("unexpected result: row %0d col %0d magnitude %0d", rsp_mon.out_row,
                rsp_mon.out_col, rsp_mon.magnitude);
         fail_count++;
      end else begin
         exp_res = edge_results_q.pop_front();
         if (rsp_mon.out_row !== exp_res.row) begin
            $error("out_row: expected %0d, actual %0d", exp_res.row, rsp_mon.out_row);
            fail_count++;
         end
         if (rsp_mon.out_col !== exp_res.col) begin
            $error("out_col: expected %0d, actual %0d", exp_res.col, rsp_mon.out_col);
            fail_count++;
         end
         if (rsp_mon.magnitude !== exp_res.mag) begin
            $error("magnitude: expected %0d, actual %0d", exp_res.mag, rsp_mon.magnitude);
            fail_count++;
         end
         if (rsp_mon.last_of_run !== exp_res.last) begin
            $error("last_of_run: expected %0d, actual %0d", exp_res.last,
                   rsp_mon.last_of_run);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COUNT_LIMIT; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         for (int i = 0; i < 6; i++) win[i] = '0;
         next_row = 0;
         next_col = 0;
         frame_w  = WIDTH_RESET;
         frame_h  = HEIGHT_RESET;
         edge_results_q.delete();
      end else begin
         // an item taken at this edge still sees the old frame size
         if (req_mon.valid && req_mon.ready) predict_pixel(req_mon.pixel);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  frame_w = csr_wdata;
               CSR_FRAME_HEIGHT: frame_h = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding = edge_results_q.size();
   end

endmodule

FILE: tb/tb_top.sv
// testbench top for the sobel core: clock, reset, pixel stimulus, result stalls and verdict
`timescale 1ns / 1ps
module tb_top;
   import sem_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int PIXEL_TARGET = 400;
   localparam int HOLD_CYCLES  = 200;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   outstanding;
   int                   fail_count;
   int                   idle_cycles = 0;
   bit                   quiet = 1'b0;
   bit                   hold_rsp = 1'b0;
   bit                   hold_done = 1'b0;
   int                   pix_seq = 0;
   int                   flat_level = 0;

   sem_req_if req_chan ();
   sem_rsp_if rsp_chan ();

   sobel_edge_magnitude_core u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   sem_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(99) >= 27);
         end
      end
   end

   // called in the falling edge time step, returns in a later one
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      while (!quiet && $urandom_range(99) < 27) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= pix;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // stop offering and let every expected item drain, plus pipeline slack
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CFG_W'($urandom_range(1025, 2047));
         2:       return CFG_W'(1024);
         3:       return CFG_W'(1);
         4:       return CFG_W'(2047);
         5:       return CFG_W'(2);
         default: return CFG_W'($urandom_range(3, 9));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] next_pixel(input int style);
      pix_seq++;
      case (style)
         0:       return PIX_W'($urandom_range(255));
         1:       return $urandom_range(1) ? PIX_W'(255) : PIX_W'(0);
         2:       return PIX_W'(pix_seq * 29);
         default: return ($urandom_range(7) == 0) ? PIX_W'($urandom_range(255))
                                                  : PIX_W'(flat_level);
      endcase
   endfunction

   initial begin
      logic [PIX_W-1:0] edge_grid [16];
      logic [CFG_W-1:0] w, h;
      int               sent, phase, n, style;
      edge_grid = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255,
                    8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // a few items under the reset frame size
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd170);
      // 4x4 frame with hard edges: clamped interior results and border zeros
      write_frame(CFG_W'(4), CFG_W'(4));
      foreach (edge_grid[i]) send_pixel(edge_grid[i]);
      // zero sizes act as one
      write_frame('0, '0);
      send_pixel(8'd255);
      send_pixel(8'd85);
      // oversize frame, clipped to the counter limit
      write_frame(CFG_W'(2047), CFG_W'(2047));
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd90);

      sent  = 0;
      phase = 0;
      while (sent < PIXEL_TARGET) begin
         if (phase == 0 || $urandom_range(3) != 0) begin
            w = pick_size();
            h = pick_size();
            write_frame(w, h);
         end else begin
            settle();
         end
         if (w >= 2 && w <= 9 && h >= 2 && h <= 9)
            n = int'(w) * int'(h) * $urandom_range(1, 2);
         else
            n = $urandom_range(5, 30);
         style      = $urandom_range(3);
         flat_level = $urandom_range(255);
         if (phase == 1) begin
            // long stretch with no idling on either side
            quiet = 1'b1;
            n     = 80;
         end
         if (phase == 2) begin
            // receiver holds off while items keep coming, so the core backs up
            quiet    = 1'b1;
            hold_rsp = 1'b1;
            n        = 48;
         end
         if (n > PIXEL_TARGET - sent) n = PIXEL_TARGET - sent;
         repeat (n) send_pixel(next_pixel(style));
         quiet = 1'b0;
         sent += n;
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/sem_pkg.sv
hdl/sem_req_if.sv
hdl/sem_rsp_if.sv
hdl/sem_ram.sv
hdl/sem_front.sv
hdl/sem_exec.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude_core.sv
tb/sem_result_checker.sv
tb/tb_top.sv
